// ----- rtl/dhtc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D-PHY HS timing package
// Shared types, constants and the table of timing writes.
// ----------------------------------------------------------------------------
package dhtc_pkg;

    localparam int RATE_W  = 12;
    localparam int BYTES_W = 9;
    localparam int NUM_W   = 20;
    localparam int DEN_W   = 17;

    localparam logic [RATE_W-1:0] RATE_MIN = 12'd80;
    localparam logic [RATE_W-1:0] RATE_MAX = 12'd2500;

    localparam logic [NUM_W-1:0] PS_PER_US = 20'd1000000;
    localparam logic [NUM_W-1:0] HP_BIAS   = 20'd1000;
    localparam logic [NUM_W-1:0] H6_BIAS   = 20'd4000;

    // Reciprocal of 125 scaled by 2^21 and rounded up. Multiplying by it and
    // keeping bits 28:21 gives the exact quotient for any 14-bit dividend.
    localparam logic [14:0] RECIP_125 = 15'd16778;

    localparam logic [3:0]  LAST_IDX = 4'd10;

    localparam logic TARGET_PHY  = 1'b0;
    localparam logic TARGET_CTRL = 1'b1;

    localparam logic [7:0] WAIT_REG = 8'hE4;

    // What is added to the rounded quotient of a write.
    localparam logic [1:0] ADD_CONST = 2'd0;
    localparam logic [1:0] ADD_HP    = 2'd1;
    localparam logic [1:0] ADD_H6    = 2'd2;

    typedef struct packed {
        logic        target;
        logic [7:0]  addr;
        logic [18:0] num;
        logic [1:0]  add_sel;
        logic [1:0]  add_k;
    } t_wr_desc;

    typedef struct packed {
        logic             start;
        logic             full;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    // Each write divides a fixed time in ps by the byte clock period.
    function automatic t_wr_desc wr_desc(input logic [3:0] idx);
        t_wr_desc d;
        begin
            d = '{target: TARGET_PHY, addr: 8'h5B, num: 19'd100000,
                  add_sel: ADD_CONST, add_k: 2'd2};
            unique case (idx)
                4'd0: d = '{TARGET_PHY,  8'h5B, 19'd100000, ADD_CONST, 2'd2};
                4'd1: d = '{TARGET_PHY,  8'h5C, 19'd38000,  ADD_CONST, 2'd0};
                4'd2: d = '{TARGET_PHY,  8'h5D, 19'd500000, ADD_CONST, 2'd2};
                4'd3: d = '{TARGET_PHY,  8'h5E, 19'd60000,  ADD_CONST, 2'd0};
                4'd4: d = '{TARGET_PHY,  8'h5F, 19'd262000, ADD_CONST, 2'd3};
                4'd5: d = '{TARGET_PHY,  8'h63, 19'd50000,  ADD_CONST, 2'd0};
                4'd6: d = '{TARGET_PHY,  8'h62, 19'd40000,  ADD_HP,    2'd0};
                4'd7: d = '{TARGET_PHY,  8'h65, 19'd105000, ADD_H6,    2'd0};
                4'd8: d = '{TARGET_PHY,  8'h64, 19'd60000,  ADD_HP,    2'd0};
                4'd9: d = '{TARGET_PHY,  8'h61, 19'd100000, ADD_CONST, 2'd1};
                4'd10: d = '{TARGET_CTRL, WAIT_REG, 19'd140000, ADD_CONST, 2'd0};
                default: d = '{TARGET_PHY, 8'h5B, 19'd100000, ADD_CONST, 2'd2};
            endcase
            return d;
        end
    endfunction

endpackage

// ----- rtl/dhtc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D-PHY HS timing front end
// Accepts a rate item, clamps it and hands the byte rate to the queue.
// ----------------------------------------------------------------------------
module dhtc_front
    import dhtc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [RATE_W-1:0]  i_rate,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [BYTES_W-1:0] o_bytes
);

    logic               r_valid;
    logic [BYTES_W-1:0] r_bytes;
    logic [RATE_W-1:0]  w_clamped;

    always_comb begin
        priority if (i_rate < RATE_MIN) begin
            w_clamped = RATE_MIN;
        end else if (i_rate > RATE_MAX) begin
            w_clamped = RATE_MAX;
        end else begin
            w_clamped = i_rate;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_bytes = r_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bytes <= w_clamped[RATE_W-1:3];
        end
    end

endmodule

// ----- rtl/dhtc_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D-PHY HS timing queue
// Short queue of byte rates between the front end and the back end.
// ----------------------------------------------------------------------------
module dhtc_fifo
    import dhtc_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [BYTES_W-1:0] i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic [BYTES_W-1:0] o_data,
    output logic               o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [BYTES_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]      r_wptr;
    logic [AW-1:0]      r_rptr;
    logic [CW-1:0]      r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ----- rtl/dhtc_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D-PHY HS timing divider
// Restoring divider, one quotient bit per cycle, full or 8-bit quotient.
// ----------------------------------------------------------------------------
module dhtc_div
    import dhtc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam logic [4:0] FULL_STEPS  = 5'd20;
    localparam logic [4:0] SHORT_STEPS = 5'd8;

    logic             r_busy;
    logic             r_done;
    logic [4:0]       r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]} - {1'b0, r_den};
    assign w_ge    = !w_trial[DEN_W];

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.full ? FULL_STEPS : SHORT_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // A quotient below 256 means the top twelve numerator bits are already
    // below the divisor, so the short form starts from them.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den <= i_req.den;
            if (i_req.full) begin
                r_rem <= '0;
                r_num <= i_req.num;
            end else begin
                r_rem <= {5'd0, i_req.num[NUM_W-1:8]};
                r_num <= {i_req.num[7:0], 12'd0};
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[DEN_W-1:0] : {r_rem[DEN_W-2:0], r_num[NUM_W-1]};
            r_num <= {r_num[NUM_W-2:0], w_ge};
        end
    end

endmodule

// ----- rtl/dhtc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D-PHY HS timing back end
// Sequences the divisions of one rate and registers the eleven writes.
// ----------------------------------------------------------------------------
module dhtc_back
    import dhtc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  logic [BYTES_W-1:0] i_q_bytes,
    output logic               o_q_pop,
    output t_div_req           o_div_req,
    input  t_div_rsp           i_div_rsp,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_target,
    output logic [7:0]         o_addr,
    output logic [7:0]         o_value,
    output logic               o_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PER  = 3'd1;
    localparam logic [2:0] ST_HP   = 3'd2;
    localparam logic [2:0] ST_WR   = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [3:0]       r_widx, n_widx;
    logic [DEN_W-1:0] r_p, n_p;
    logic [7:0]       r_hp, n_hp;
    logic [7:0]       r_h6, n_h6;
    logic             r_ovalid;
    logic             r_otarget;
    logic [7:0]       r_oaddr;
    logic [7:0]       r_oval;
    logic             r_olast;

    t_wr_desc         w_desc;
    t_wr_desc         w_desc_nx;
    logic [3:0]       w_widx_nx;
    logic [7:0]       w_addend;
    logic [7:0]       w_value;
    logic             w_slot_free;
    logic             w_load;
    logic [NUM_W-1:0] w_half_p;
    logic [NUM_W-1:0] w_p6;
    logic [NUM_W-1:0] w_hp_num;
    logic [NUM_W-1:0] w_h6_num;
    logic [13:0]      w_hp_y;
    logic [13:0]      w_h6_y;
    logic [28:0]      w_hp_prod;
    logic [28:0]      w_h6_prod;

    assign w_widx_nx   = r_widx + 1'b1;
    assign w_desc      = wr_desc(r_widx);
    assign w_desc_nx   = wr_desc(w_widx_nx);
    assign w_slot_free = !r_ovalid || i_ready;
    assign w_half_p    = {4'd0, r_p[DEN_W-1:1]};
    assign w_p6        = {1'b0, r_p, 2'b00} + {2'b00, r_p, 1'b0};

    // The rounded P/2000 and 6P/8000 terms. A divide by 2000 is a shift by
    // four and a divide by 125, a divide by 8000 a shift by six and a divide
    // by 125; the divide by 125 is a multiply by its scaled reciprocal.
    assign w_hp_num  = {3'd0, r_p} + HP_BIAS;
    assign w_h6_num  = w_p6 + H6_BIAS;
    assign w_hp_y    = 14'(w_hp_num >> 4);
    assign w_h6_y    = w_h6_num[NUM_W-1:6];
    assign w_hp_prod = {15'd0, w_hp_y} * {14'd0, RECIP_125};
    assign w_h6_prod = {15'd0, w_h6_y} * {14'd0, RECIP_125};

    always_comb begin
        unique case (w_desc.add_sel)
            ADD_HP:  w_addend = r_hp;
            ADD_H6:  w_addend = r_h6;
            default: w_addend = {6'd0, w_desc.add_k};
        endcase
    end

    assign w_value = i_div_rsp.quot[7:0] + w_addend;

    always_comb begin
        n_state   = r_state;
        n_widx    = r_widx;
        n_p       = r_p;
        n_hp      = r_hp;
        n_h6      = r_h6;
        o_q_pop   = 1'b0;
        w_load    = 1'b0;
        o_div_req = '{start: 1'b0, full: 1'b0, num: '0, den: '0};
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop   = 1'b1;
                    n_widx    = '0;
                    o_div_req = '{1'b1, 1'b1, PS_PER_US, {8'd0, i_q_bytes}};
                    n_state   = ST_PER;
                end
            end
            ST_PER: begin
                if (i_div_rsp.done) begin
                    n_p     = i_div_rsp.quot[DEN_W-1:0];
                    n_state = ST_HP;
                end
            end
            ST_HP: begin
                n_hp      = w_hp_prod[28:21];
                n_h6      = w_h6_prod[28:21];
                o_div_req = '{1'b1, 1'b0, {1'b0, w_desc.num} + w_half_p, r_p};
                n_state   = ST_WR;
            end
            ST_WR: begin
                if (i_div_rsp.done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    w_load = 1'b1;
                    if (r_widx == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_widx    = w_widx_nx;
                        o_div_req = '{1'b1, 1'b0, {1'b0, w_desc_nx.num} + w_half_p, r_p};
                        n_state   = ST_WR;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_widx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_widx  <= n_widx;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p  <= n_p;
        r_hp <= n_hp;
        r_h6 <= n_h6;
        if (w_load) begin
            r_otarget <= w_desc.target;
            r_oaddr   <= w_desc.addr;
            r_oval    <= w_value;
            r_olast   <= (r_widx == LAST_IDX);
        end
    end

    assign o_valid  = r_ovalid;
    assign o_target = r_otarget;
    assign o_addr   = r_oaddr;
    assign o_value  = r_oval;
    assign o_last   = r_olast;

endmodule

// ----- rtl/dphy_hs_timing_calculator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// D-PHY HS timing calculator
// Turns a link bit rate into the eleven D-PHY high-speed timing writes.
// ----------------------------------------------------------------------------
// Each input item carries a link bit rate in Mbps, clamped to 80..2500. The
// block derives the byte clock period in ps as 1000000 / (rate / 8), then
// eleven timing counts rounded to nearest, and sends them as eleven output
// items: ten PHY test-code writes (tuser = 0) followed by the PHY wait time
// for controller register 0xE4 (tuser = 1, tlast = 1). The front end takes a
// new rate every cycle into a short queue, so the input side does not wait
// on the output side until the queue is full. In the back end, the period
// runs through the shared bit-serial divider in 20 steps, then a state
// derives the rounded P/2000 and 6P/8000 terms from a reciprocal multiply,
// and each of the eleven writes takes an 8-step short division and an emit
// state. The back end takes the next rate from the queue only after the last
// write of the previous rate is emitted. If the output side stalls, the back
// end holds the next write and the divider waits with it.
// ----------------------------------------------------------------------------
module dphy_hs_timing_calculator_unit
    import dhtc_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [11:0] rate_mbps, [15:12] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // [7:0] address, [15:8] value
    output logic [0:0]  o_m_axis_tuser,  // [0] target
    output logic        o_m_axis_tlast
);

    logic               w_f_valid;
    logic               w_f_ready;
    logic [BYTES_W-1:0] w_f_bytes;
    logic               w_q_full;
    logic               w_q_empty;
    logic               w_q_pop;
    logic [BYTES_W-1:0] w_q_bytes;
    logic               w_push;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;
    logic               w_target;
    logic [7:0]         w_addr;
    logic [7:0]         w_value;

    assign w_f_ready = !w_q_full;
    assign w_push    = w_f_valid && !w_q_full;

    // Clamp and byte-rate stage.
    dhtc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_rate  (i_s_axis_tdata[RATE_W-1:0]),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_bytes (w_f_bytes)
    );

    // Decouples rate acceptance from the long computation.
    dhtc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_f_bytes),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_bytes),
        .o_empty (w_q_empty)
    );

    // The one divider shared by every division of a rate.
    dhtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // Division sequencer and output register.
    dhtc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_bytes (w_q_bytes),
        .o_q_pop   (w_q_pop),
        .o_div_req (w_div_req),
        .i_div_rsp (w_div_rsp),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_target  (w_target),
        .o_addr    (w_addr),
        .o_value   (w_value),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {w_value, w_addr};
    assign o_m_axis_tuser = w_target;

    // Only the wait-time write goes to the controller, and it closes the run.
    a_last_is_ctrl : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (o_m_axis_tuser[0] == TARGET_CTRL)))
        else $error("tlast and controller target disagree");

    // The queue is never popped empty.
    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("queue popped while empty");

    // The divider reports each result for a single cycle only.
    a_start_after_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |=> !w_div_rsp.done)
        else $error("divider done held for two cycles");

endmodule

// ----- tb/tb_dphy_hs_timing_calculator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the D-PHY HS timing calculator
// Sends link rates over the input stream and checks each of the eleven timing
// writes that come back against a local computation of the same counts.
// ----------------------------------------------------------------------------
// The checked behavior covers several parts:
// - clamping of the rate to 80..2500,
// - the truncating period divide,
// - the round-to-nearest counts with their offsets,
// - the order, targets and addresses of the writes,
// - tlast on the wait-time write.
// Both stream sides idle at random. One phase holds the output off long
// enough to fill the input queue. Another lets the sender drain completely.
// ----------------------------------------------------------------------------
module tb_dphy_hs_timing_calculator_unit;
    import dhtc_pkg::*;

    // PHY test codes of the ten timing writes, in the order the block emits them.
    localparam logic [7:0] TC_CLK_THS_EXIT = 8'h5B;
    localparam logic [7:0] TC_CLK_PREPARE  = 8'h5C;
    localparam logic [7:0] TC_CLK_REQUEST  = 8'h5D;
    localparam logic [7:0] TC_CLK_TRAIL    = 8'h5E;
    localparam logic [7:0] TC_CLK_ZERO     = 8'h5F;
    localparam logic [7:0] TC_DATA_REQUEST = 8'h63;
    localparam logic [7:0] TC_DATA_PREPARE = 8'h62;
    localparam logic [7:0] TC_DATA_ZERO    = 8'h65;
    localparam logic [7:0] TC_DATA_TRAIL   = 8'h64;
    localparam logic [7:0] TC_DATA_EXIT    = 8'h61;

    // A long output hold-off must be shorter than the watchdog limit by a wide margin.
    localparam int HOLD_CYCLES    = 2000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int MAX_GAP        = 16;

    typedef struct packed {
        logic       target;
        logic [7:0] addr;
        logic [7:0] value;
        logic       last;
    } t_timing_write;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;

    // Expected writes, oldest first.
    t_timing_write pending_writes[$];

    // Idle controls for each side, switched per stretch of items.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int rx_wait = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    int errors = 0;
    int rates_sent = 0;
    int rates_clamped = 0;
    int writes_checked = 0;

    dphy_hs_timing_calculator_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),         // [11:0] rate_mbps, [15:12] zero
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),  // [7:0] address, [15:8] value
        .o_m_axis_tuser  (o_m_axis_tuser),  // [0] target
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    // Round-to-nearest integer division, as the block uses for every count.
    function automatic int unsigned round_div(input int unsigned num, input int unsigned den);
        return (num + den / 2) / den;
    endfunction

    // Computes the eleven writes caused by one rate and queues them.
    function automatic void predict_timing_writes(input logic [11:0] rate_in);
        int unsigned rate;
        int unsigned period;
        int unsigned half_ps;
        int unsigned counts[10];
        logic [7:0]  codes[10];
        t_timing_write w;
        rate = 32'(rate_in);
        if (rate < 32'(RATE_MIN)) rate = 32'(RATE_MIN);
        if (rate > 32'(RATE_MAX)) rate = 32'(RATE_MAX);
        // Byte clock period in ps; both divisions truncate.
        period  = 32'(PS_PER_US) / (rate / 8);
        half_ps = round_div(period, 2000);
        codes  = '{TC_CLK_THS_EXIT, TC_CLK_PREPARE, TC_CLK_REQUEST, TC_CLK_TRAIL,
                   TC_CLK_ZERO, TC_DATA_REQUEST, TC_DATA_PREPARE, TC_DATA_ZERO,
                   TC_DATA_TRAIL, TC_DATA_EXIT};
        counts[0] = round_div(100000, period) + 2;
        counts[1] = round_div(38000, period);
        counts[2] = round_div(500000, period) + 2;
        counts[3] = round_div(60000, period);
        counts[4] = round_div(262000, period) + 3;
        counts[5] = round_div(50000, period);
        counts[6] = round_div(40000, period) + half_ps;
        counts[7] = round_div(105000, period) + round_div(period * 6, 8000);
        counts[8] = round_div(60000, period) + half_ps;
        counts[9] = round_div(100000, period) + 1;
        for (int k = 0; k < 10; k++) begin
            w = '{target: TARGET_PHY, addr: codes[k], value: counts[k][7:0], last: 1'b0};
            pending_writes.push_back(w);
        end
        // The PHY wait time closes the run, written to the controller register.
        w = '{target: TARGET_CTRL, addr: WAIT_REG,
              value: 8'(round_div(140000, period)), last: 1'b1};
        pending_writes.push_back(w);
    endfunction

    // Offers one rate, after an optional random gap, and waits until the block
    // takes it. tvalid stays high afterwards so that back-to-back items do not
    // drop it; the next call or the drain lowers it.
    task automatic send_rate(input logic [11:0] rate);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, rate};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_timing_writes(rate);
        rates_sent++;
        if (rate < RATE_MIN || rate > RATE_MAX) rates_clamped++;
    endtask

    // Stops offering and waits until every expected write has come back.
    task automatic drain_writes();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Clamp boundaries, the truncation of rate/8, and bit patterns.
    task automatic test_clamp_and_extremes();
        logic [11:0] rates[$];
        rates = '{12'd0, 12'd1, 12'd79, 12'd80, 12'd81, 12'd87, 12'd88, 12'd95,
                  12'd2499, 12'd2500, 12'd2501, 12'd4095, 12'd2048, 12'd1000,
                  12'd1500, 12'd123, 12'h555, 12'hAAA, 12'h7FF, 12'h800};
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        foreach (rates[i]) send_rate(rates[i]);
        drain_writes();
    endtask

    // Mostly in-range rates, with clamped and full-width values mixed in.
    // The idle mode of each side is drawn anew every 25 items.
    task automatic test_random_rates(input int count);
        logic [11:0] rate;
        int mode;
        for (int i = 0; i < count; i++) begin
            if (i % 25 == 0) begin
                mode = $urandom_range(0, 3);
                tx_idle_on = mode[0];
                rx_idle_on = mode[1];
            end
            case ($urandom_range(0, 9))
                0, 1:    rate = 12'($urandom_range(0, 4095));
                2:       rate = 12'($urandom_range(0, 79));
                3:       rate = 12'($urandom_range(2501, 4095));
                default: rate = 12'($urandom_range(80, 2500));
            endcase
            send_rate(rate);
        end
        drain_writes();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // items back to back, so that the input queue fills and tready drops.
    task automatic test_backpressure_fill();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_left <= HOLD_CYCLES;
        for (int i = 0; i < 12; i++) send_rate(12'($urandom_range(80, 2500)));
        drain_writes();
    endtask

    // Short bursts with a full drain in between, so the block goes idle
    // between bursts.
    task automatic test_drain_pause();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int b = 0; b < 3; b++) begin
            for (int i = 0; i < 3; i++) send_rate(12'($urandom_range(0, 4095)));
            drain_writes();
        end
    endtask

    // Output side: per write it draws a random wait, bounded by MAX_GAP, unless
    // idling is off. A requested hold-off overrides everything while it counts down.
    always @(posedge i_clk) begin
        int w;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (m_tready && o_m_axis_tvalid) begin
            w = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            m_tready <= (w == 0);
            rx_wait  <= w;
        end else if (!m_tready) begin
            if (rx_wait > 1) begin
                rx_wait <= rx_wait - 1;
            end else begin
                rx_wait  <= 0;
                m_tready <= 1'b1;
            end
        end
    end

    // Compares every accepted write with the oldest expectation.
    always @(posedge i_clk) begin
        t_timing_write got;
        t_timing_write exp_w;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got = '{target: o_m_axis_tuser[0], addr: o_m_axis_tdata[7:0],
                    value: o_m_axis_tdata[15:8], last: o_m_axis_tlast};
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected write target=%0d addr=%h value=%0d last=%0d",
                         $time, got.target, got.addr, got.value, got.last);
                errors++;
            end else begin
                exp_w = pending_writes.pop_front();
                writes_checked++;
                if (got.target !== exp_w.target) begin
                    $display("%0t: target mismatch: expected %0d, got %0d",
                             $time, exp_w.target, got.target);
                    errors++;
                end
                if (got.addr !== exp_w.addr) begin
                    $display("%0t: address mismatch: expected %h, got %h",
                             $time, exp_w.addr, got.addr);
                    errors++;
                end
                if (got.value !== exp_w.value) begin
                    $display("%0t: value mismatch at addr %h: expected %0d, got %0d",
                             $time, exp_w.addr, exp_w.value, got.value);
                    errors++;
                end
                if (got.last !== exp_w.last) begin
                    $display("%0t: tlast mismatch at addr %h: expected %0d, got %0d",
                             $time, exp_w.addr, exp_w.last, got.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any cycle without a handshake on either side counts toward the limit.
    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d writes still expected", $time, pending_writes.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_clamp_and_extremes();
        test_random_rates(180);
        test_backpressure_fill();
        test_drain_pause();
        test_random_rates(200);

        // Anything that shows up after the last expected write is a failure.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_writes.size() != 0) begin
            $display("%0t: %0d expected writes never arrived", $time, pending_writes.size());
            errors++;
        end

        $display("Covered %0d rates (%0d outside 80..2500) and checked %0d timing writes,",
                 rates_sent, rates_clamped, writes_checked);
        $display("with random idling on both sides, a full input queue and drained pauses.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
